FILE: design/rskv_pkg.sv
// shared types, codes and constants for the random sample key/value table
`timescale 1ns / 1ps
package rskv_pkg;

  // default table depth and width of the external draw
  localparam int CAPACITY_DEF = 16;
  localparam int DRAW_W       = 15;
  localparam int DIV_CNT_W    = $clog2(DRAW_W);

  // request modes
  localparam logic [1:0] MODE_GET    = 2'd0;
  localparam logic [1:0] MODE_SET    = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;
  localparam logic [1:0] MODE_RANDOM = 2'd3;

  // response status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  typedef struct packed {
    logic [1:0]          mode;
    logic signed [31:0]  key;
    logic signed [31:0]  value;
    logic [DRAW_W-1:0]   random_draw;
  } req_t;

  typedef struct packed {
    logic signed [31:0] value_out;
    logic [1:0]         status;
  } rsp_t;

  // read address source
  typedef enum logic [1:0] {
    RD_SCAN = 2'd0,
    RD_LAST = 2'd1,
    RD_REM  = 2'd2
  } rd_sel_t;

  // table write operation
  typedef enum logic [1:0] {
    WR_NONE        = 2'd0,
    WR_VAL_AT_SCAN = 2'd1,
    WR_APPEND      = 2'd2,
    WR_MOVE        = 2'd3
  } wr_sel_t;

  // response value and status pairs
  typedef enum logic [2:0] {
    RES_RDVAL_OK    = 3'd0,
    RES_NONE_ABSENT = 3'd1,
    RES_ZERO_OK     = 3'd2,
    RES_ZERO_FULL   = 3'd3,
    RES_ZERO_ABSENT = 3'd4,
    RES_NONE_EMPTY  = 3'd5
  } res_kind_t;

  typedef struct packed {
    logic      capture;
    logic      scan_clr;
    logic      scan_inc;
    logic      div_start;
    logic      div_step;
    rd_sel_t   rd_sel;
    wr_sel_t   wr_sel;
    logic      res_load;
    res_kind_t res_kind;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       count_zero;
    logic       count_full;
    logic       scan_end;
    logic       key_match;
    logic       div_last;
    logic       out_free;
  } sts_t;

endpackage

FILE: design/rskv_dp.sv
// datapath: key and value memories, entry count, scan index, remainder unit, response register
`timescale 1ns / 1ps
module rskv_dp #(
  parameter int CAPACITY = rskv_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  rskv_pkg::req_t req,
  input  logic          rsp_stall,
  output logic          rsp_valid,
  output rskv_pkg::rsp_t rsp,
  input  rskv_pkg::cmd_t cmd,
  output rskv_pkg::sts_t sts
);
  import rskv_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  req_t              item;
  logic [CW-1:0]     count;
  logic [CW-1:0]     last;
  logic [CW-1:0]     scan_idx;
  logic [31:0]       key_mem [CAPACITY];
  logic [31:0]       val_mem [CAPACITY];
  logic [31:0]       key_rd;
  logic [31:0]       val_rd;
  logic [IW-1:0]     rd_addr;
  logic [IW-1:0]     wr_addr;
  logic [31:0]       key_wdata;
  logic [31:0]       val_wdata;
  logic              key_we;
  logic              val_we;
  logic [DRAW_W-1:0] draw_sh;
  logic [CW-1:0]     rem;
  logic [CW:0]       rem_sh;
  logic [CW:0]       rem_diff;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic signed [31:0] res_value;
  logic [1:0]        res_status;

  assign last = count - CW'(1);

  // captured request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= req;
    end
  end

  // scan index over occupied slots
  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      scan_idx <= '0;
    end else if (cmd.scan_inc) begin
      scan_idx <= scan_idx + CW'(1);
    end
  end

  // read address select
  always_comb begin
    unique case (cmd.rd_sel)
      RD_LAST: rd_addr = last[IW-1:0];
      RD_REM:  rd_addr = rem[IW-1:0];
      default: rd_addr = scan_idx[IW-1:0];
    endcase
  end

  // write port select
  always_comb begin
    key_we    = (cmd.wr_sel == WR_APPEND) || (cmd.wr_sel == WR_MOVE);
    val_we    = (cmd.wr_sel != WR_NONE);
    wr_addr   = (cmd.wr_sel == WR_APPEND) ? count[IW-1:0] : scan_idx[IW-1:0];
    key_wdata = (cmd.wr_sel == WR_APPEND) ? item.key : key_rd;
    val_wdata = (cmd.wr_sel == WR_MOVE) ? val_rd : item.value;
  end

  // table memories, registered read
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= key_wdata;
    end
    if (val_we) begin
      val_mem[wr_addr] <= val_wdata;
    end
    key_rd <= key_mem[rd_addr];
    val_rd <= val_mem[rd_addr];
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.wr_sel == WR_APPEND) begin
      count <= count + CW'(1);
    end else if (cmd.wr_sel == WR_MOVE) begin
      count <= last;
    end
  end

  // restoring remainder of draw by count, one bit per cycle
  assign rem_sh   = {rem, draw_sh[DRAW_W-1]};
  assign rem_diff = rem_sh - {1'b0, count};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      draw_sh <= item.random_draw;
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      draw_sh <= {draw_sh[DRAW_W-2:0], 1'b0};
      rem     <= (rem_sh >= {1'b0, count}) ? rem_diff[CW-1:0] : rem_sh[CW-1:0];
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      unique case (cmd.res_kind)
        RES_RDVAL_OK: begin
          res_value  <= val_rd;
          res_status <= ST_OK;
        end
        RES_NONE_ABSENT: begin
          res_value  <= '1;
          res_status <= ST_ABSENT;
        end
        RES_ZERO_FULL: begin
          res_value  <= '0;
          res_status <= ST_FULL;
        end
        RES_ZERO_ABSENT: begin
          res_value  <= '0;
          res_status <= ST_ABSENT;
        end
        RES_NONE_EMPTY: begin
          res_value  <= '1;
          res_status <= ST_EMPTY;
        end
        default: begin
          res_value  <= '0;
          res_status <= ST_OK;
        end
      endcase
    end
  end

  // output register, drained by the receiver
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.value_out <= res_value;
      rsp.status    <= res_status;
    end
  end

  // status to the controller
  always_comb begin
    sts.mode       = item.mode;
    sts.count_zero = (count == '0);
    sts.count_full = (count == CW'(CAPACITY));
    sts.scan_end   = (scan_idx == count);
    sts.key_match  = (key_rd == item.key);
    sts.div_last   = (div_cnt == DIV_CNT_W'(DRAW_W - 1));
    sts.out_free   = !rsp_valid || !rsp_stall;
  end

endmodule

FILE: design/rskv_ctrl.sv
// controller state machine sequencing lookup, update, move and sampling
`timescale 1ns / 1ps
module rskv_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  rskv_pkg::sts_t sts,
  output rskv_pkg::cmd_t cmd
);
  import rskv_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_DISPATCH = 10'b00_0000_0010,
    S_SCAN_RD  = 10'b00_0000_0100,
    S_SCAN_CMP = 10'b00_0000_1000,
    S_MOVE_RD  = 10'b00_0001_0000,
    S_MOVE_WR  = 10'b00_0010_0000,
    S_DIV      = 10'b00_0100_0000,
    S_RAND_RD  = 10'b00_1000_0000,
    S_RAND_VAL = 10'b01_0000_0000,
    S_OUT      = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign req_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RD_SCAN;
    cmd.wr_sel = WR_NONE;
    cmd.res_kind = RES_ZERO_OK;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.scan_clr = 1'b1;
        if (sts.mode == MODE_RANDOM) begin
          if (sts.count_zero) begin
            cmd.res_load = 1'b1;
            cmd.res_kind = RES_NONE_EMPTY;
            state_next   = S_OUT;
          end else begin
            cmd.div_start = 1'b1;
            state_next    = S_DIV;
          end
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      // present the next slot, or settle a miss
      S_SCAN_RD: begin
        if (sts.scan_end) begin
          cmd.res_load = 1'b1;
          state_next   = S_OUT;
          case (sts.mode)
            MODE_GET: cmd.res_kind = RES_NONE_ABSENT;
            MODE_SET: begin
              if (sts.count_full) begin
                cmd.res_kind = RES_ZERO_FULL;
              end else begin
                cmd.wr_sel   = WR_APPEND;
                cmd.res_kind = RES_ZERO_OK;
              end
            end
            default: cmd.res_kind = RES_ZERO_ABSENT;
          endcase
        end else begin
          state_next = S_SCAN_CMP;
        end
      end
      // compare the slot read back
      S_SCAN_CMP: begin
        if (sts.key_match) begin
          cmd.res_load = 1'b1;
          case (sts.mode)
            MODE_GET: begin
              cmd.res_kind = RES_RDVAL_OK;
              state_next   = S_OUT;
            end
            MODE_SET: begin
              cmd.wr_sel   = WR_VAL_AT_SCAN;
              cmd.res_kind = RES_ZERO_OK;
              state_next   = S_OUT;
            end
            default: begin
              cmd.res_kind = RES_ZERO_OK;
              state_next   = S_MOVE_RD;
            end
          endcase
        end else begin
          cmd.scan_inc = 1'b1;
          state_next   = S_SCAN_RD;
        end
      end
      S_MOVE_RD: begin
        cmd.rd_sel = RD_LAST;
        state_next = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        cmd.wr_sel = WR_MOVE;
        state_next = S_OUT;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_RAND_RD;
        end
      end
      S_RAND_RD: begin
        cmd.rd_sel = RD_REM;
        state_next = S_RAND_VAL;
      end
      S_RAND_VAL: begin
        cmd.res_load = 1'b1;
        cmd.res_kind = RES_RDVAL_OK;
        state_next   = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: design/random_sample_key_value_table.sv
// top level of the random sample key/value table
// Usage:
//   req channel (req_valid/req_stall/req) carries mode, key, value and random_draw.
//   rsp channel (rsp_valid/rsp_stall/rsp) returns value_out and status, one per request.
//   A transfer happens at a clock edge with valid high and stall low.
// Operation, one request at a time:
//   get/set/delete scan slots in ascending order, each slot examined taking a
//   memory read, then a compare; a delete that finds its key then moves the
//   last pair into the freed slot.
//   random sample runs a 15-step restoring remainder of the draw by the entry
//   count, then one memory read; an empty table answers with status empty.
// The response sits in an output register; a new request is taken while it
//   waits, and the block holds in its final state while that register is
//   still occupied and stalled.
// Reset (rst, synchronous) empties the table, clears the response valid and
//   returns to idle; the stores need no clearing since only slots below the
//   count are read.
`timescale 1ns / 1ps
module random_sample_key_value_table #(
  parameter int CAPACITY = rskv_pkg::CAPACITY_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  rskv_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output rskv_pkg::rsp_t rsp
);
  import rskv_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing
  rskv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // storage and arithmetic
  rskv_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .cmd       (cmd),
    .sts       (sts)
  );

  // no append into a full table
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_sel == WR_APPEND) |-> !sts.count_full)
    else $error("append issued into a full table");

  // a pending response is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(rsp_valid && rsp_stall))
    else $error("response register overwritten while stalled");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request taken while another is in progress");

  // remainder unit never runs with an empty table
  a_div_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> !sts.count_zero)
    else $error("remainder by zero count");

endmodule

FILE: dv/tb_top.sv
// testbench for the random sample key/value table: directed and random traffic against a shadow table
`timescale 1ns / 1ps
module tb_top;
  import rskv_pkg::*;

  localparam int TBL_DEPTH   = CAPACITY_DEF;
  localparam int KEY_POOL_N  = 22;
  localparam int RAND_PHASES = 15;
  localparam int PHASE_ITEMS = 100;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  // shadow copy of the table contents
  logic signed [31:0] shadow_keys [TBL_DEPTH];
  logic signed [31:0] shadow_vals [TBL_DEPTH];
  int                 shadow_count;
  int                 peak_count;

  rsp_t               pending_results [$];
  logic signed [31:0] key_pool [KEY_POOL_N];

  int  error_cnt;
  int  accepted_cnt;
  int  result_cnt;
  int  status_seen [4];
  bit  tx_calm;
  bit  rx_calm;
  int  press_hold;
  int  rx_seg_left;

  random_sample_key_value_table #(.CAPACITY(TBL_DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // overall time limit
  initial begin
    #10_000_000;
    $display("TIMEOUT: %0d requests accepted, %0d results pending",
             accepted_cnt, pending_results.size());
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_error(input string msg);
    error_cnt++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // idle length: mostly short, a few long
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // shadow table update, returns the expected response
  function automatic rsp_t predict_response(input req_t item);
    rsp_t exp_r;
    int   slot;
    int   i;
    exp_r.value_out = '0;
    exp_r.status    = ST_OK;
    slot = -1;
    for (i = 0; i < shadow_count; i++)
      if (slot < 0 && shadow_keys[i] == item.key) slot = i;
    case (item.mode)
      MODE_GET: begin
        if (slot >= 0) begin
          exp_r.value_out = shadow_vals[slot];
        end else begin
          exp_r.value_out = -32'sd1;
          exp_r.status    = ST_ABSENT;
        end
      end
      MODE_SET: begin
        if (slot >= 0) begin
          shadow_vals[slot] = item.value;
        end else if (shadow_count >= TBL_DEPTH) begin
          exp_r.status = ST_FULL;
        end else begin
          shadow_keys[shadow_count] = item.key;
          shadow_vals[shadow_count] = item.value;
          shadow_count++;
        end
      end
      MODE_DELETE: begin
        if (slot >= 0) begin
          shadow_keys[slot] = shadow_keys[shadow_count-1];
          shadow_vals[slot] = shadow_vals[shadow_count-1];
          shadow_count--;
        end else begin
          exp_r.status = ST_ABSENT;
        end
      end
      default: begin
        if (shadow_count == 0) begin
          exp_r.value_out = -32'sd1;
          exp_r.status    = ST_EMPTY;
        end else begin
          exp_r.value_out = shadow_vals[int'(item.random_draw) % shadow_count];
        end
      end
    endcase
    if (shadow_count > peak_count) peak_count = shadow_count;
    return exp_r;
  endfunction

  // one request transfer; entered and left at a falling edge
  task automatic send_request(input req_t item);
    int   gap;
    rsp_t exp_r;
    req       = item;
    req_valid = 1'b1;
    do @(posedge clk); while (req_stall);
    accepted_cnt++;
    exp_r = predict_response(item);
    pending_results = {pending_results, exp_r};
    @(negedge clk);
    gap = (tx_calm || $urandom_range(0, 99) < 55) ? 0 : idle_len();
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_op(input logic [1:0] mode, input logic signed [31:0] key,
                         input logic signed [31:0] value, input logic [DRAW_W-1:0] draw);
    req_t item;
    item.mode        = mode;
    item.key         = key;
    item.value       = value;
    item.random_draw = draw;
    send_request(item);
  endtask

  // stop offering and wait for every expected response
  task automatic wait_drained();
    req_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // response side stall pattern, with the long hold-off when asked for
  always @(negedge clk) begin
    if (press_hold > 0) begin
      rsp_stall = 1'b1;
      press_hold--;
    end else if (rx_seg_left > 0) begin
      rx_seg_left--;
    end else if (rx_calm) begin
      rsp_stall = 1'b0;
    end else begin
      rsp_stall   = ($urandom_range(0, 99) < 35);
      rx_seg_left = rsp_stall ? idle_len() - 1 : $urandom_range(0, 4);
    end
  end

  // compare each response transfer with the oldest expectation
  always @(posedge clk) begin
    rsp_t exp_r;
    if (!rst && rsp_valid && !rsp_stall) begin
      result_cnt++;
      status_seen[rsp.status]++;
      if (pending_results.size() == 0) begin
        report_error($sformatf("unexpected response value_out=%0d status=%0d",
                               rsp.value_out, rsp.status));
      end else begin
        exp_r = pending_results.pop_front();
        if (rsp.value_out !== exp_r.value_out)
          report_error($sformatf("response %0d value_out got %0d exp %0d",
                                 result_cnt, rsp.value_out, exp_r.value_out));
        if (rsp.status !== exp_r.status)
          report_error($sformatf("response %0d status got %0d exp %0d",
                                 result_cnt, rsp.status, exp_r.status));
      end
    end
  end

  // operations on the empty table
  task automatic test_empty_table();
    send_op(MODE_RANDOM, 32'sd0, 32'sd0, '1);
    send_op(MODE_GET,    32'sd5, 32'sd0, '0);
    send_op(MODE_DELETE, 32'sd5, 32'sd0, '0);
  endtask

  // extreme keys and values, update in place, sample, delete of slot 0
  task automatic test_basic_ops();
    send_op(MODE_SET,    32'sh8000_0000, 32'sh7fff_ffff, '0);
    send_op(MODE_SET,    32'sh7fff_ffff, 32'sh8000_0000, '0);
    send_op(MODE_SET,    32'sd0,         -32'sd1,        '0);
    send_op(MODE_SET,    -32'sd1,        32'sd0,         '1);
    send_op(MODE_GET,    32'sh8000_0000, 32'sd0,         '0);
    send_op(MODE_SET,    -32'sd1,        32'sd5,         '0);
    send_op(MODE_GET,    -32'sd1,        32'sd0,         '0);
    send_op(MODE_RANDOM, 32'sd0,         32'sd0,         '1);
    send_op(MODE_DELETE, 32'sh8000_0000, 32'sd0,         '0);
  endtask

  // fill up, set into a full table, then drop the last slot
  task automatic test_full_table();
    logic signed [31:0] last_key;
    last_key = '0;
    while (shadow_count < TBL_DEPTH) begin
      last_key = 32'sd1000 + shadow_count;
      send_op(MODE_SET, last_key, $urandom, '0);
    end
    send_op(MODE_SET,    32'sd77, 32'sd1, '0);
    send_op(MODE_RANDOM, 32'sd0,  32'sd0, '0);
    send_op(MODE_DELETE, last_key, 32'sd0, '0);
  endtask

  // response side held off while requests keep coming
  task automatic test_backpressure();
    int n;
    tx_calm    = 1'b1;
    press_hold = 300;
    for (n = 0; n < 10; n++)
      send_op(($urandom_range(0, 1) != 0) ? MODE_GET : MODE_RANDOM,
              key_pool[$urandom_range(0, KEY_POOL_N-1)], $urandom,
              DRAW_W'($urandom_range(0, 32767)));
    tx_calm = 1'b0;
    wait_drained();
  endtask

  function automatic logic signed [31:0] pick_key();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 25 && shadow_count > 0)
      return shadow_keys[$urandom_range(0, shadow_count-1)];
    if (roll < 85) return key_pool[$urandom_range(0, KEY_POOL_N-1)];
    return $urandom;
  endfunction

  // phases that lean toward filling, draining or a mix
  task automatic test_random_traffic();
    int         ph;
    int         n;
    int         roll;
    int         w_set;
    int         w_del;
    logic [1:0] mode;
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph % 3)
        0:       begin w_set = 55; w_del = 10; end
        1:       begin w_set = 15; w_del = 50; end
        default: begin w_set = 30; w_del = 25; end
      endcase
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < w_set)              mode = MODE_SET;
        else if (roll < w_set + w_del) mode = MODE_DELETE;
        else if (roll < w_set + w_del + (100 - w_set - w_del) / 2) mode = MODE_GET;
        else                           mode = MODE_RANDOM;
        send_op(mode, pick_key(), $urandom, DRAW_W'($urandom_range(0, 32767)));
      end
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  // main sequence
  initial begin
    int i;
    rst          = 1'b1;
    req_valid    = 1'b0;
    req          = '0;
    rsp_stall    = 1'b0;
    tx_calm      = 1'b0;
    rx_calm      = 1'b0;
    press_hold   = 0;
    rx_seg_left  = 0;
    shadow_count = 0;
    peak_count   = 0;
    error_cnt    = 0;
    accepted_cnt = 0;
    result_cnt   = 0;
    for (i = 0; i < 4; i++) status_seen[i] = 0;
    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh7fff_ffff;
    key_pool[2] = 32'sd0;
    key_pool[3] = -32'sd1;
    for (i = 4; i < KEY_POOL_N; i++) key_pool[i] = $urandom;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    test_empty_table();
    test_basic_ops();
    test_full_table();
    test_backpressure();
    test_random_traffic();

    req_valid = 1'b0;
    wait_drained();
    repeat (60) @(negedge clk);

    $display("covered %0d requests and %0d responses, peak occupancy %0d of %0d",
             accepted_cnt, result_cnt, peak_count, TBL_DEPTH);
    $display("statuses seen: ok %0d, absent %0d, full %0d, empty %0d",
             status_seen[ST_OK], status_seen[ST_ABSENT], status_seen[ST_FULL],
             status_seen[ST_EMPTY]);
    if (error_cnt == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
